// File: hdl/chd_pkg.sv
// Shared constants and types for the chunked body decoder.
// Used by the parser front end, the result queue and the output stage.
package chd_pkg;

    localparam int SIZE_BITS = 24;     // chunk size width, 8..32
    localparam int DROP_W    = 24;     // width of the drop count field
    localparam int QDEPTH    = 2;      // result queue entries
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // One result item as it leaves the parser.
    typedef struct packed {
        logic [7:0]        payload_byte;
        logic              has_byte;
        logic              done_res;
        logic              truncated;
        logic [DROP_W-1:0] drop_count;
    } chd_item_t;

endpackage

// File: hdl/http_chunked_body_decoder_unit.sv
// Chunked transfer body decoder, top level.
// Depends on chd_pkg, chd_front, chd_queue and chd_back.
//
// Slave side takes one body byte per item on s_tdata, with s_tlast on the final
// byte of the body. Master side gives one item per decoded payload byte and one
// for the final body byte (m_tlast). On that final item m_tuser[1] flags a body
// that ended inside chunk data, and the upper tdata bits give how many of the
// payload bytes already sent (this one included) belong to the cut chunk.
// Size lines, the CR LF after them and the two bytes after each chunk make no
// item unless they are the final byte.
// Throughput: one byte per cycle sustained while s_tready is high; the parser
// updates its state once per byte. A result is written into the queue at the
// edge that takes its byte, then moved to the output register that drives the
// master side.
// When the receiver stalls, the two-entry queue and output register absorb
// results; s_tready drops once the queue is full, and then every byte waits,
// including those that make no item. Reset (aresetn low, synchronous) empties
// the queue, clears m_tvalid and returns the parser to the start of a size line;
// the parser also returns there after every final body byte.
module http_chunked_body_decoder_unit import chd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] body_byte
    input  logic              s_tlast,    // end_of_body
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DROP_W+7:0] m_tdata,    // [7:0] payload_byte, [31:8] drop_count
    output logic [1:0]        m_tuser,    // [0] has_byte, [1] truncated
    output logic              m_tlast     // done_res
);

    logic      q_full, q_empty, q_push, q_pop;
    chd_item_t q_in, q_head;

    chd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .in_ready (s_tready),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    chd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_item (q_head)
    );

    chd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // truncation is only ever reported on the final item
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("truncated without end of body");

    // a drop count comes only with truncation
    a_drop_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[DROP_W+7:8] == '0)
        else $error("drop count without truncation");

    // every item carries a byte or ends the body
    a_item_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] || m_tlast)
        else $error("empty result item");

    // a stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed under stall");

endmodule

// File: hdl/chd_front.sv
// Parser front end: runs the chunk framing state machine, one byte per cycle
// unless the queue is full, and queues result items. Depends on chd_pkg.
module chd_front import chd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       in_ready,
    output logic       q_push,
    output chd_item_t  q_item
);

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_REST   = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [1:0] DS_NONE = 2'd0;
    localparam logic [1:0] DS_ZERO = 2'd1;
    localparam logic [1:0] DS_MORE = 2'd2;

    localparam logic [1:0] SKIP_COUNT = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    typedef struct packed {
        logic [2:0]           phase;
        logic [SIZE_BITS-1:0] acc;
        logic [1:0]           dseen;
    } line_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // 16 means "not a hex digit"
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        return v;
    endfunction

    function automatic line_t line_char(input line_t st, input logic [7:0] c);
        line_t                r;
        logic [4:0]           v;
        logic [SIZE_BITS+3:0] nv;
        logic                 go;
        r  = st;
        go = 1'b1;
        v  = hex_val(c);
        nv = {st.acc, 4'h0} + (SIZE_BITS + 4)'(v[3:0]);
        if (st.phase == PH_LEAD) begin
            if (is_space(c)) begin
                go = 1'b0;
            end else if (c == CH_PLUS) begin
                r.phase = PH_DIGITS;
                go      = 1'b0;
            end else if (c == CH_MINUS) begin
                r.phase = PH_DONE;
                go      = 1'b0;
            end else begin
                r.phase = PH_DIGITS;
            end
        end
        if (go && r.phase == PH_DIGITS) begin
            if (!v[4]) begin
                if (nv[SIZE_BITS+3:SIZE_BITS] != 4'h0) begin
                    r.phase = PH_DONE;
                end else begin
                    r.acc   = nv[SIZE_BITS-1:0];
                    r.dseen = (st.dseen == DS_NONE && v == 5'd0) ? DS_ZERO : DS_MORE;
                end
            end else if ((c == CH_LX || c == CH_UX) && st.dseen == DS_ZERO) begin
                r.dseen = DS_MORE;
            end else begin
                r.phase = (st.dseen == DS_NONE) ? PH_DONE : PH_REST;
            end
        end
        return r;
    endfunction

    logic [2:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic                 pcr_reg, pcr_next;
    logic [1:0]           skip_reg, skip_next;
    logic [1:0]           dseen_reg, dseen_next;

    logic                 accept;
    logic                 has;
    logic                 trunc;
    logic [SIZE_BITS-1:0] consumed;
    line_t                ln;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        pcr_next   = pcr_reg;
        skip_next  = skip_reg;
        dseen_next = dseen_reg;
        has        = 1'b0;
        trunc      = 1'b0;
        consumed   = '0;
        ln         = '{phase: phase_reg, acc: acc_reg, dseen: dseen_reg};

        if (phase_reg == PH_LEAD || phase_reg == PH_DIGITS || phase_reg == PH_REST) begin
            if (pcr_reg && in_byte == CH_LF) begin
                // CR LF closes the size line
                pcr_next = 1'b0;
                if (dseen_reg == DS_NONE || acc_reg == '0) begin
                    ln.phase = PH_DONE;
                end else begin
                    left_next = acc_reg;
                    ln.phase  = PH_DATA;
                end
            end else begin
                if (pcr_reg) ln = line_char(ln, CH_CR);  // lone CR is a line char
                pcr_next = 1'b0;
                if (ln.phase == PH_LEAD || ln.phase == PH_DIGITS || ln.phase == PH_REST) begin
                    if (in_byte == CH_CR) pcr_next = 1'b1;
                    else ln = line_char(ln, in_byte);
                end
            end
            phase_next = ln.phase;
            acc_next   = ln.acc;
            dseen_next = ln.dseen;
        end else if (phase_reg == PH_DATA) begin
            has = 1'b1;
            if (left_reg != '0) left_next = left_reg - 1'b1;
            if (left_next == '0) begin
                phase_next = PH_SKIP;
                skip_next  = SKIP_COUNT;
            end
        end else if (phase_reg == PH_SKIP) begin
            if (skip_reg > 2'd1) begin
                skip_next = skip_reg - 1'b1;
            end else begin
                skip_next  = '0;
                phase_next = PH_LEAD;
                acc_next   = '0;
                pcr_next   = 1'b0;
                dseen_next = DS_NONE;
            end
        end

        if (in_last) begin
            if (phase_next == PH_DATA && left_next != '0) begin
                trunc    = 1'b1;
                consumed = acc_next - left_next;
            end
            phase_next = PH_LEAD;
            acc_next   = '0;
            left_next  = '0;
            pcr_next   = 1'b0;
            skip_next  = '0;
            dseen_next = DS_NONE;
        end
    end

    assign q_push              = accept && (has || in_last);
    assign q_item.payload_byte = has ? in_byte : 8'h00;
    assign q_item.has_byte     = has;
    assign q_item.done_res     = in_last;
    assign q_item.truncated    = trunc;
    assign q_item.drop_count   = DROP_W'(consumed);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            left_reg  <= '0;
            pcr_reg   <= 1'b0;
            skip_reg  <= '0;
            dseen_reg <= DS_NONE;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            pcr_reg   <= pcr_next;
            skip_reg  <= skip_next;
            dseen_reg <= dseen_next;
        end
    end

endmodule

// File: hdl/chd_queue.sv
// Short result queue between the parser and the output stage.
// Depends on chd_pkg for the item type and depth.
module chd_queue import chd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  chd_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output chd_item_t head_item
);

    chd_item_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= bump(wptr_reg);
            if (pop)  rptr_reg <= bump(rptr_reg);
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: hdl/chd_back.sv
// Output stage: pulls result items from the queue into the master-side register
// and packs them onto the stream. Depends on chd_pkg.
module chd_back import chd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  chd_item_t             q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DROP_W+7:0]     m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    chd_item_t out_reg;
    logic      valid_reg;
    logic      load;

    assign load  = !valid_reg || m_tready;
    assign q_pop = load && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (load) valid_reg <= !q_empty;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) out_reg <= q_head;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_reg.drop_count, out_reg.payload_byte};
    assign m_tuser  = {out_reg.truncated, out_reg.has_byte};
    assign m_tlast  = out_reg.done_res;

endmodule
